FILE: hdl/four_byte_string_fold_hash_defines.svh
// Assertion macros shared by the string folding hash RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FOUR_BYTE_STRING_FOLD_HASH_DEFINES_SVH
`define FOUR_BYTE_STRING_FOLD_HASH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FBSFH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBSFH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fbsfh_pkg.sv
// Types and constants for the four-byte string folding hash.
// No dependencies; used by four_byte_string_fold_hash.
package fbsfh_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 32;
  localparam int unsigned HashW   = 31;
  localparam int unsigned PosW    = 2;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [HashW-1:0] TableSizeReset  = HashW'(1024);
  localparam logic             CharSignedReset = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgTableSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCharSigned = 1'b1;

  localparam logic [CntW-1:0] DivLastStep = CntW'(SumW - 1);

  typedef enum logic [1:0] {
    StAccum,
    StAbs,
    StDivide,
    StHold
  } fbsfh_state_e;

  // Extend a key byte to the accumulator width, as signed or unsigned char.
  function automatic logic [SumW-1:0] extend_byte(input logic [ByteW-1:0] b,
                                                  input logic             sgn);
    logic [SumW-1:0] ext;
    ext = {{(SumW-ByteW){sgn & b[ByteW-1]}}, b};
    return ext;
  endfunction

endpackage

FILE: hdl/four_byte_string_fold_hash.sv
// Four-byte string folding hash: accumulator, magnitude and iterative modulo.
// Depends on fbsfh_pkg and four_byte_string_fold_hash_defines.svh.
//
// Key bytes are taken one per cycle and folded into a wrapping 32-bit sum,
// each byte weighted by 256 to the power of its position modulo 4. An item
// that is not last is accepted every cycle. An item marked last closes the
// key: the block then stalls its input while it takes the magnitude of the
// sum and reduces it modulo table_size with a restoring shift-subtract
// divider that retires one dividend bit per cycle, then moves the result into
// the output register once the output side is free, so a stalled output side
// keeps the input stalled. A table_size of zero yields hash_index 0.
// Configuration writes are always taken and must be issued while no key is
// being closed.
`include "four_byte_string_fold_hash_defines.svh"

module four_byte_string_fold_hash (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbsfh_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fbsfh_pkg::HashW-1:0]       cfg_data_i,
  // Key byte requests.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fbsfh_pkg::ByteW-1:0]       key_byte_i,
  input  logic                              byte_valid_i,
  input  logic                              last_i,
  // Hash results.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fbsfh_pkg::HashW-1:0]       hash_index_o
);

  localparam int unsigned SumW  = fbsfh_pkg::SumW;
  localparam int unsigned HashW = fbsfh_pkg::HashW;

  fbsfh_pkg::fbsfh_state_e state_q, state_d;

  logic [HashW-1:0]            table_size_q, table_size_d;
  logic                        char_signed_q, char_signed_d;
  logic [SumW-1:0]             fold_sum_q, fold_sum_d;
  logic [fbsfh_pkg::PosW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]             quot_q, quot_d;
  logic [SumW-1:0]             rem_q, rem_d;
  logic [fbsfh_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [HashW-1:0]            hash_q, hash_d;

  logic            in_accept;
  logic            out_free;
  logic [SumW-1:0] addend;
  logic [SumW-1:0] sum_next;
  logic [SumW-1:0] trial;
  logic [SumW-1:0] divisor;
  logic            fits;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;

  assign addend   = fbsfh_pkg::extend_byte(key_byte_i, char_signed_q)
                    << {pos_q, 3'b000};
  assign sum_next = byte_valid_i ? fold_sum_q + addend : fold_sum_q;

  // Shared shift-subtract step of the divider. The remainder stays below the
  // divisor, so its top bit is always clear and the shifted trial fits.
  assign trial   = {rem_q[SumW-2:0], quot_q[SumW-1]};
  assign divisor = {1'b0, table_size_q};
  assign fits    = trial >= divisor;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbsfh_pkg::StAccum: begin
        if (in_accept && last_i) state_d = fbsfh_pkg::StAbs;
      end
      fbsfh_pkg::StAbs: begin
        state_d = fbsfh_pkg::StDivide;
      end
      fbsfh_pkg::StDivide: begin
        if (cnt_q == fbsfh_pkg::DivLastStep) state_d = fbsfh_pkg::StHold;
      end
      fbsfh_pkg::StHold: begin
        if (out_free) state_d = fbsfh_pkg::StAccum;
      end
      default: state_d = fbsfh_pkg::StAccum;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_stall_o    = 1'b1;
    fold_sum_d    = fold_sum_q;
    pos_d         = pos_q;
    quot_d        = quot_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q & out_stall_i;
    hash_d        = hash_q;
    unique case (state_q)
      fbsfh_pkg::StAccum: begin
        in_stall_o = 1'b0;
        if (in_accept) begin
          if (last_i) begin
            quot_d     = sum_next;
            fold_sum_d = '0;
            pos_d      = '0;
          end else begin
            fold_sum_d = sum_next;
            if (byte_valid_i) pos_d = pos_q + 1'b1;
          end
        end
      end
      fbsfh_pkg::StAbs: begin
        // Two's complement magnitude; the most negative sum gives 2^31.
        if (quot_q[SumW-1]) quot_d = ~quot_q + 1'b1;
        rem_d = '0;
        cnt_d = '0;
      end
      fbsfh_pkg::StDivide: begin
        rem_d  = fits ? trial - divisor : trial;
        quot_d = {quot_q[SumW-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
      end
      fbsfh_pkg::StHold: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hash_d      = (table_size_q == '0) ? '0 : rem_q[HashW-1:0];
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Configuration register writes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    table_size_d  = table_size_q;
    char_signed_d = char_signed_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fbsfh_pkg::CfgTableSize:  table_size_d  = cfg_data_i;
        fbsfh_pkg::CfgCharSigned: char_signed_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fbsfh_pkg::StAccum;
      table_size_q  <= fbsfh_pkg::TableSizeReset;
      char_signed_q <= fbsfh_pkg::CharSignedReset;
      fold_sum_q    <= '0;
      pos_q         <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      table_size_q  <= table_size_d;
      char_signed_q <= char_signed_d;
      fold_sum_q    <= fold_sum_d;
      pos_q         <= pos_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    hash_q <= hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_index_o = hash_q;

  `FBSFH_ASSERT_NXT(a_last_clears_key, in_accept && last_i,
                    state_q == fbsfh_pkg::StAbs && fold_sum_q == '0 && pos_q == '0,
                    "closing request did not clear the key state")
  `FBSFH_ASSERT_IMP(a_rem_top_clear, state_q == fbsfh_pkg::StDivide, !rem_q[SumW-1],
                    "divider remainder overflowed")
  `FBSFH_ASSERT_NXT(a_div_ends, state_q == fbsfh_pkg::StDivide &&
                    cnt_q == fbsfh_pkg::DivLastStep, state_q == fbsfh_pkg::StHold,
                    "divider did not finish after its last step")
  `FBSFH_ASSERT_NXT(a_hold_loads, state_q == fbsfh_pkg::StHold && out_free,
                    out_valid_q && state_q == fbsfh_pkg::StAccum,
                    "finished hash was not moved to the output register")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the four-byte string folding hash.
// Needs fbsfh_pkg and four_byte_string_fold_hash; a scoreboard class predicts
// each hash index from the accepted key bytes and the register settings.
module tb;
  import fbsfh_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ItemTarget  = 1750;
  localparam int unsigned PhaseCount  = 8;

  class FoldHashScoreboard;
    logic [HashW-1:0] table_size;
    logic             char_signed;
    logic [SumW-1:0]  fold_sum;
    logic [PosW-1:0]  byte_pos;
    logic [HashW-1:0] expected_hash[$];
    int               errors;

    function new();
      table_size  = TableSizeReset;
      char_signed = CharSignedReset;
      fold_sum    = '0;
      byte_pos    = '0;
      errors      = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [HashW-1:0] data);
      case (idx)
        CfgTableSize:  table_size = data;
        CfgCharSigned: char_signed = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [ByteW-1:0] b, logic bv, logic l);
      logic [SumW-1:0] ext;
      logic [SumW-1:0] mag;
      logic [SumW-1:0] rem;
      if (bv) begin
        ext      = {{(SumW-ByteW){char_signed & b[ByteW-1]}}, b};
        fold_sum = fold_sum + (ext << {byte_pos, 3'b000});
        byte_pos = byte_pos + 1'b1;
      end
      if (l) begin
        // The most negative sum has magnitude 2^31 when read as unsigned.
        mag = fold_sum[SumW-1] ? (~fold_sum + 1'b1) : fold_sum;
        rem = (table_size == '0) ? '0 : mag % SumW'(table_size);
        expected_hash.push_back(rem[HashW-1:0]);
        fold_sum = '0;
        byte_pos = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %0s", msg);
    endtask

    task check_result(logic [HashW-1:0] got);
      logic [HashW-1:0] want;
      if (expected_hash.size() == 0) begin
        report($sformatf("unexpected hash_index %0d", got));
      end else begin
        want = expected_hash.pop_front();
        if (got !== want)
          report($sformatf("hash_index %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_hash.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [HashW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   key_byte_i = '0;
  logic               byte_valid_i = 1'b0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [HashW-1:0]   hash_index_o;

  FoldHashScoreboard sb = new();

  int unsigned burst_left = 0;
  bit          gaps_on = 1'b0;
  int unsigned items_sent = 0;
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;

  four_byte_string_fold_hash uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_byte_i   (key_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_index_o (hash_index_o)
  );

  always #10 clk_i = ~clk_i;

  // Results are checked before requests are noted, so a write or a request at
  // the same edge never disturbs the expectation being compared.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(hash_index_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_request(key_byte_i, byte_valid_i, last_i);
    end
  end

  // The result side switches between stall styles, each picked at random.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= ((stall_cycle % 7) < 3);
    endcase
  end

  task automatic idle_cycles(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_item(input logic [ByteW-1:0] b, input logic bv, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    key_byte_i   <= b;
    byte_valid_i <= bv;
    last_i       <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (bv || l) items_sent++;
  endtask

  // Stops the sender, waits for every outstanding hash and lets the divider
  // finish before anything else happens.
  task automatic settle();
    int unsigned waited;
    idle_cycles(1);
    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d hash results never arrived", sb.pending()));
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [HashW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [HashW-1:0] size, input logic sgn);
    logic [HashW-1:0] noise;
    noise = HashW'($urandom());
    settle();
    write_register(CfgTableSize, size);
    write_register(CfgCharSigned, {noise[HashW-1:1], sgn});
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return ByteW'($urandom());
    endcase
  endfunction

  function automatic logic [HashW-1:0] pick_size(input int unsigned phase);
    case (phase)
      0: return HashW'(1);
      1: return {HashW{1'b1}};
      default: begin
        case ($urandom_range(0, 3))
          0: return HashW'($urandom_range(1, 64));
          1: return HashW'(1) << $urandom_range(0, HashW-1);
          default: return HashW'($urandom());
        endcase
      end
    endcase
  endfunction

  task automatic send_random_key();
    int unsigned len;
    int unsigned pick;
    bit          bare_close;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      bare_close = ($urandom_range(0, 7) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_item(ByteW'($urandom()), 1'b0, 1'b0);
        send_item(pick_byte(), 1'b1, !bare_close && (i == len - 1));
      end
      if (bare_close) send_item(ByteW'($urandom()), 1'b0, 1'b1);
    end else if (pick < 92) begin
      send_item(ByteW'($urandom()), 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) send_item(ByteW'($urandom()), 1'b0, 1'b0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty key, a single negative byte, the most negative sum.
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // A byte-less item inside a key is ignored; a bare end marker closes it.
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h3C, 1'b0, 1'b1);

    // Largest table, unsigned bytes, five bytes so the position wraps.
    configure({HashW{1'b1}}, 1'b0);
    repeat (4) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    configure(HashW'(1), 1'b1);
    send_item(8'h12, 1'b1, 1'b1);
    configure('0, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);

    // Changing the byte extension in the middle of a key.
    configure(HashW'(1000), 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h81, 1'b1, 1'b0);
    settle();
    write_register(CfgCharSigned, HashW'(0));
    send_item(8'h82, 1'b1, 1'b0);
    send_item(8'h83, 1'b1, 1'b1);

    items_sent = 0;
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      configure(pick_size(phase), phase[0] ^ 1'($urandom_range(0, 1)));
      gaps_on = (phase % 3 != 2);
      while (items_sent < ((phase + 1) * ItemTarget) / PhaseCount) begin
        send_random_key();
        if ($urandom_range(0, 39) == 0) settle();
        if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fbsfh_pkg.sv
hdl/four_byte_string_fold_hash.sv
tb/tb.sv
